### sv/lcps_pkg.sv
// Package for the LED chaser pattern sequencer: payload types, mode codes,
// configuration register indexes and reset constants.
// No dependencies.
package lcps_pkg;

    localparam int unsigned LedW     = 8;
    localparam int unsigned PeriodW  = 16;
    localparam int unsigned ModeW    = 3;
    localparam int unsigned IdxW     = 3;
    localparam int unsigned NumModes = 6;
    localparam int unsigned CfgIdxW  = 2;

    localparam logic [PeriodW-1:0] CNT_MAX             = 16'hffff;
    localparam logic [PeriodW-1:0] SHIFT_PERIOD_RESET  = 16'd100;
    localparam logic [PeriodW-1:0] FLOWER_PERIOD_RESET = 16'd300;

    localparam logic [LedW-1:0] LED_ONE        = 8'h01;
    localparam logic [LedW-1:0] LED_TOP        = 8'h80;
    localparam logic [LedW-1:0] LED_CENTER_HI  = 8'h10;
    localparam logic [LedW-1:0] LED_CENTER_LO  = 8'h08;
    localparam logic [LedW-1:0] LED_BLANK      = 8'h00;
    localparam logic [LedW-1:0] LED_FULL       = 8'hff;

    // Pattern modes; codes 6 and 7 are unused and freeze the pattern
    typedef enum logic [ModeW-1:0] {
        MODE_WALK_LEFT     = 3'd0,
        MODE_WALK_RIGHT    = 3'd1,
        MODE_FILL_LEFT     = 3'd2,
        MODE_FILL_RIGHT    = 3'd3,
        MODE_FLOWER_GROW   = 3'd4,
        MODE_FLOWER_SHRINK = 3'd5
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODE          = 2'd0,
        CFG_SHIFT_PERIOD  = 2'd1,
        CFG_FLOWER_PERIOD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic tick;
    } t_in_item;

    typedef struct packed {
        logic [LedW-1:0] led_bits;
        logic            stepped;
    } t_out_item;

endpackage

### sv/lcps_stream_if.sv
// Valid/ready stream interface used by both channels of the sequencer.
// The payload type is set per instance; depends on nothing else.
interface lcps_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/led_chaser_pattern_sequencer.sv
// Top level of the LED chaser pattern sequencer: counter, per-mode step
// indexes, LED port and output register. Uses lcps_pkg and lcps_stream_if.
//
//   channel  | dir | payload            | handshake
//   ---------+-----+--------------------+-------------------
//   i_in     | in  | tick               | valid / ready
//   o_out    | out | led_bits, stepped  | valid / ready
//   cfg      | in  | mode, periods      | i_cfg_we, no wait
//
// One poll is accepted per cycle; its result appears in the output register
// the next cycle. The single output register sets the rate: a poll is taken
// whenever the register is empty or is being drained in the same cycle.
// A stalled output holds its transaction and blocks further polls.
// Reset is synchronous: mode 0, periods 100 and 300 ms, port, counter and
// all step indexes cleared.
module led_chaser_pattern_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lcps_stream_if.sink                     i_in,
    lcps_stream_if.source                   o_out,
    input  logic                            i_cfg_we,
    input  logic [lcps_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [lcps_pkg::PeriodW-1:0]    i_cfg_data
);
    import lcps_pkg::*;

    logic [ModeW-1:0]   r_mode;
    logic [PeriodW-1:0] r_shift_period;
    logic [PeriodW-1:0] r_flower_period;
    logic [PeriodW-1:0] r_cnt;
    logic [PeriodW-1:0] n_cnt;
    logic [LedW-1:0]    r_led;
    logic [LedW-1:0]    n_led;
    logic [IdxW-1:0]    r_idx [NumModes];
    logic [IdxW-1:0]    n_idx_val;
    logic               n_idx_we;
    logic               n_stepped;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               in_fire;
    logic [PeriodW-1:0] cnt_inc;
    logic [IdxW-1:0]    cur_idx;
    logic [1:0]         flw_idx;
    logic               shift_hit;
    logic               flower_hit;
    logic [LedW-1:0]    left_bit;
    logic [LedW-1:0]    right_bit;
    logic [LedW-1:0]    flower_base;
    logic [LedW-1:0]    grow_bits;
    logic [LedW-1:0]    shrink_bits;

    // Take a poll when the output register is free or draining
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Saturating millisecond count, then the step conditions
    assign cnt_inc    = (i_in.data.tick && (r_cnt != CNT_MAX)) ? r_cnt + 1'b1 : r_cnt;
    assign cur_idx    = (r_mode < ModeW'(NumModes)) ? r_idx[r_mode[IdxW-1:0]] : '0;
    assign flw_idx    = cur_idx[1:0];
    assign shift_hit  = (cnt_inc >= r_shift_period);
    assign flower_hit = (cnt_inc >= r_flower_period);

    // Pattern bits for the current index
    assign left_bit    = LED_ONE << cur_idx;
    assign right_bit   = LED_TOP >> cur_idx;
    assign grow_bits   = (LED_CENTER_HI << flw_idx) | (LED_CENTER_LO >> flw_idx);
    assign shrink_bits = (LED_TOP >> flw_idx) | (LED_ONE << flw_idx);

    // Flower modes restart from a blank or full port at index zero
    always_comb begin
        if (flw_idx == 2'd0) begin
            flower_base = (t_mode'(r_mode) == MODE_FLOWER_GROW) ? LED_BLANK : LED_FULL;
        end else begin
            flower_base = r_led;
        end
    end

    // Next port, counter and index for the accepted poll
    always_comb begin
        n_cnt     = cnt_inc;
        n_led     = r_led;
        n_idx_we  = 1'b0;
        n_idx_val = cur_idx + 1'b1;
        n_stepped = 1'b0;
        unique case (t_mode'(r_mode))
            MODE_WALK_LEFT, MODE_WALK_RIGHT, MODE_FILL_LEFT, MODE_FILL_RIGHT: begin
                if (shift_hit) begin
                    n_cnt     = '0;
                    n_idx_we  = 1'b1;
                    n_stepped = 1'b1;
                    unique case (t_mode'(r_mode))
                        MODE_WALK_LEFT:  n_led = left_bit;
                        MODE_WALK_RIGHT: n_led = right_bit;
                        MODE_FILL_LEFT:  n_led = r_led | left_bit;
                        default:         n_led = r_led | right_bit;
                    endcase
                end
            end
            MODE_FLOWER_GROW, MODE_FLOWER_SHRINK: begin
                n_led     = flower_base;
                n_idx_val = {1'b0, flw_idx + 2'd1};
                if (flower_hit) begin
                    n_cnt     = '0;
                    n_idx_we  = 1'b1;
                    n_stepped = 1'b1;
                    if (t_mode'(r_mode) == MODE_FLOWER_GROW) begin
                        n_led = flower_base | grow_bits;
                    end else begin
                        n_led = flower_base & ~shrink_bits;
                    end
                end
            end
            default: begin
                // Unused modes: only the counter moves
                n_cnt = cnt_inc;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= ModeW'(MODE_WALK_LEFT);
            r_shift_period  <= SHIFT_PERIOD_RESET;
            r_flower_period <= FLOWER_PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:          r_mode          <= i_cfg_data[ModeW-1:0];
                CFG_SHIFT_PERIOD:  r_shift_period  <= i_cfg_data;
                CFG_FLOWER_PERIOD: r_flower_period <= i_cfg_data;
                default:           r_mode          <= r_mode;
            endcase
        end
    end

    // Pattern state: update on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_led <= '0;
            for (int k = 0; k < NumModes; k++) begin
                r_idx[k] <= '0;
            end
        end else if (in_fire) begin
            r_cnt <= n_cnt;
            r_led <= n_led;
            if (n_idx_we) begin
                r_idx[r_mode[IdxW-1:0]] <= n_idx_val;
            end
        end
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data.led_bits <= n_led;
            r_out_data.stepped  <= n_stepped;
        end
    end

endmodule
